// ===== rtl/iss_pkg.sv =====
// shared types and constants for the indexed sequence store
// no dependencies; used by every module of the block
`default_nettype none

package iss_pkg;

	localparam int DEPTH     = 64;
	localparam int IDX_W     = $clog2(DEPTH);
	localparam int CNT_W     = $clog2(DEPTH + 1);
	localparam int POS_W     = 6;
	localparam int WORD_W    = 32;
	localparam int OUT_CNT_W = 7;
	localparam int CMP_W     = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam int GRP_SZ    = 8;
	localparam int NGRP      = (DEPTH + GRP_SZ - 1) / GRP_SZ;

	typedef enum logic [2:0] {
		MODE_APPEND       = 3'd0,
		MODE_PREPEND      = 3'd1,
		MODE_INSERT_AT    = 3'd2,
		MODE_READ_AT      = 3'd3,
		MODE_DELETE_FIRST = 3'd4,
		MODE_DELETE_LAST  = 3'd5,
		MODE_DELETE_AT    = 3'd6,
		MODE_NOP          = 3'd7
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	// per-cycle command broadcast along the chain of cells
	typedef struct packed {
		logic             ins;
		logic             del;
		logic             take;
		logic [IDX_W-1:0] pos;
	} op_t;

	// bookkeeping that travels with an item to the output
	typedef struct packed {
		status_t          status;
		logic [CNT_W-1:0] count;
	} res_t;

endpackage

`default_nettype wire

// ===== rtl/iss_cell.sv =====
// one storage cell of the chain: holds a word, shifts from a neighbor
// depends on iss_pkg
`default_nettype none

module iss_cell (
	input  logic                       clk,
	input  iss_pkg::op_t               op,
	input  logic [iss_pkg::IDX_W-1:0]  index,
	input  logic [iss_pkg::WORD_W-1:0] value,
	input  logic [iss_pkg::WORD_W-1:0] left,
	input  logic [iss_pkg::WORD_W-1:0] right,
	output logic [iss_pkg::WORD_W-1:0] data,
	output logic [iss_pkg::WORD_W-1:0] take_word
);
	import iss_pkg::*;

	logic [WORD_W-1:0] data_q;
	logic              hit;

	assign hit       = (index == op.pos);
	assign data      = data_q;
	assign take_word = (op.take && hit) ? data_q : '0;

	always_ff @(posedge clk) begin
		if (op.ins && (index > op.pos)) begin
			data_q <= left;
		end else if (op.ins && hit) begin
			data_q <= value;
		end else if (op.del && (index >= op.pos)) begin
			data_q <= right;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/iss_ctrl.sv =====
// request decoder and word count: resolves the effective position and status
// depends on iss_pkg
`default_nettype none

module iss_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      accept,
	input  logic [2:0]                mode,
	input  logic [iss_pkg::POS_W-1:0] position,
	output iss_pkg::op_t              op,
	output iss_pkg::res_t             res
);
	import iss_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_d;
	logic             full;
	logic             empty;
	logic [CMP_W-1:0] pos_c;
	logic [CMP_W-1:0] cnt_c;
	logic [CMP_W-1:0] last_c;
	logic [IDX_W-1:0] last_idx;
	mode_t            m;

	assign m        = mode_t'(mode);
	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign pos_c    = CMP_W'(position);
	assign cnt_c    = CMP_W'(count_q);
	assign last_c   = CMP_W'(count_q - CNT_W'(1));
	assign last_idx = IDX_W'(count_q - CNT_W'(1));

	always_comb begin
		op         = '0;
		res.status = ST_OK;
		count_d    = count_q;
		case (m)
			MODE_APPEND, MODE_PREPEND, MODE_INSERT_AT: begin
				if (full) begin
					res.status = ST_FULL;
				end else begin
					op.ins  = accept;
					count_d = count_q + CNT_W'(1);
					if (m == MODE_PREPEND || (m == MODE_INSERT_AT && position == '0)) begin
						op.pos = '0;
					end else if (m == MODE_APPEND || pos_c >= cnt_c) begin
						op.pos = IDX_W'(count_q);
					end else begin
						op.pos = IDX_W'(position);
					end
				end
			end
			MODE_READ_AT: begin
				if (pos_c >= cnt_c) begin
					res.status = ST_RANGE;
				end else begin
					op.take = accept;
					op.pos  = IDX_W'(position);
				end
			end
			MODE_DELETE_FIRST, MODE_DELETE_LAST, MODE_DELETE_AT: begin
				if (empty) begin
					res.status = ST_EMPTY;
				end else begin
					op.del  = accept;
					op.take = accept;
					count_d = count_q - CNT_W'(1);
					if (m == MODE_DELETE_FIRST || (m == MODE_DELETE_AT && position == '0)) begin
						op.pos = '0;
					end else if (m == MODE_DELETE_LAST || pos_c >= last_c) begin
						op.pos = last_idx;
					end else begin
						op.pos = IDX_W'(position);
					end
				end
			end
			default: begin
				res.status = ST_OK;
			end
		endcase
		res.count = count_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= count_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/indexed_sequence_store_unit.sv =====
// top level of the indexed sequence store: decoder, chain of cells, read tree
// depends on iss_pkg, iss_ctrl, iss_cell
`default_nettype none

// Ordered store of up to 64 signed 32-bit words kept as a chain of cells.
// A request is taken on any cycle with start high; busy stays low, so one
// request can enter every cycle. Inserts and deletes shift all later cells
// by one in the cycle the request is taken, each cell comparing its own
// index with the resolved position. The word read or removed goes through
// a two-level registered OR tree (groups of eight cells, then the groups),
// so each result appears with done behind the group and output registers,
// in request order. The receiver cannot stall: every result must be taken
// in the cycle done is high.

module indexed_sequence_store_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [2:0]                    mode,
	input  logic [iss_pkg::POS_W-1:0]     position,
	input  logic signed [iss_pkg::WORD_W-1:0] value,
	output logic                          done,
	output logic signed [iss_pkg::WORD_W-1:0] word,
	output logic [iss_pkg::OUT_CNT_W-1:0] count,
	output logic [1:0]                    status
);
	import iss_pkg::*;

	logic              accept;
	op_t               op;
	res_t              res;
	logic [WORD_W-1:0] data [DEPTH];
	logic [WORD_W-1:0] take [DEPTH];
	logic [WORD_W-1:0] grp_d [NGRP];
	logic [WORD_W-1:0] grp_s1 [NGRP];
	logic [WORD_W-1:0] word_d;
	logic              valid_s1;
	res_t              res_s1;
	logic              done_q;
	logic [WORD_W-1:0] word_q;
	res_t              res_q;

	// the chain shifts within the accepting cycle, so nothing ever holds off
	assign busy   = 1'b0;
	assign accept = start && !busy;

	iss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.mode     (mode),
		.position (position),
		.op       (op),
		.res      (res)
	);

	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		logic [WORD_W-1:0] left_w;
		logic [WORD_W-1:0] right_w;
		if (k == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = data[k-1];
		end
		if (k == DEPTH - 1) begin : g_last
			assign right_w = data[k];
		end else begin : g_mid_r
			assign right_w = data[k+1];
		end
		iss_cell u_cell (
			.clk       (clk),
			.op        (op),
			.index     (IDX_W'(k)),
			.value     (value),
			.left      (left_w),
			.right     (right_w),
			.data      (data[k]),
			.take_word (take[k])
		);
	end

	// first tree level: one select-OR per group of eight cells
	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_d[g] = '0;
			for (int j = 0; j < GRP_SZ; j++) begin
				if (g * GRP_SZ + j < DEPTH) begin
					grp_d[g] = grp_d[g] | take[g * GRP_SZ + j];
				end
			end
		end
	end

	always_comb begin
		word_d = '0;
		for (int g = 0; g < NGRP; g++) begin
			word_d = word_d | grp_s1[g];
		end
	end

	always_ff @(posedge clk) begin
		grp_s1 <= grp_d;
		res_s1 <= res;
		word_q <= word_d;
		res_q  <= res_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= accept;
			done_q   <= valid_s1;
		end
	end

	assign done   = done_q;
	assign word   = word_q;
	assign count  = OUT_CNT_W'(res_q.count);
	assign status = res_q.status;

	a_accept_to_stage: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted item did not enter the read stage");

	a_stage_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> done)
		else $error("read stage item did not produce a result");

	a_error_word_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_OK) |-> (word == '0))
		else $error("error result carries a nonzero word");

	a_full_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_FULL) |-> (count == OUT_CNT_W'(DEPTH)))
		else $error("full status reported with count below capacity");

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// self-checking testbench for indexed_sequence_store_unit: directed table, then random requests
// keeps its own copy of the ordered store and checks each result against it or its typed entry
// depends on rtl/iss_pkg.sv and rtl/indexed_sequence_store_unit.sv
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import iss_pkg::*;

	localparam int N_RANDOM  = 1500;
	localparam int CALM_TAIL = 200;

	typedef struct {
		mode_t              mode;
		logic [POS_W-1:0]   pos;
		logic signed [31:0] val;
		bit                 typed;
		logic signed [31:0] word;
		logic [6:0]         cnt;
		status_t            st;
	} request_t;

	typedef struct {
		logic signed [31:0] word;
		logic [6:0]         cnt;
		status_t            st;
	} reply_t;

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	mode_t                    mode_r;
	logic [POS_W-1:0]         pos_r;
	logic signed [WORD_W-1:0] val_r;
	logic                     done;
	logic signed [WORD_W-1:0] word;
	logic [OUT_CNT_W-1:0]     count;
	logic [1:0]               status;

	// typed expectation that travels with the item being offered
	bit                 cur_typed;
	logic signed [31:0] cur_word;
	logic [6:0]         cur_cnt;
	status_t            cur_st;

	logic signed [31:0] shadow_cells [DEPTH];
	int                 shadow_count;
	reply_t             pending_replies [$];
	request_t           directed [$];
	int                 fail_count;

	indexed_sequence_store_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.mode     (mode_r),
		.position (pos_r),
		.value    (val_r),
		.done     (done),
		.word     (word),
		.count    (count),
		.status   (status)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// apply one request to the shadow store and work out its reply
	function automatic reply_t apply_request(mode_t m, logic [POS_W-1:0] p,
			logic signed [31:0] v);
		reply_t r;
		int     at;
		r.word = '0;
		r.st   = ST_OK;
		case (m)
			MODE_APPEND, MODE_PREPEND, MODE_INSERT_AT: begin
				if (shadow_count >= DEPTH) begin
					r.st = ST_FULL;
				end else begin
					if (m == MODE_PREPEND || (m == MODE_INSERT_AT && p == 0))
						at = 0;
					else if (m == MODE_APPEND || int'(p) >= shadow_count)
						at = shadow_count;
					else
						at = int'(p);
					for (int k = shadow_count; k > at; k--)
						shadow_cells[k] = shadow_cells[k-1];
					shadow_cells[at] = v;
					shadow_count++;
				end
			end
			MODE_READ_AT: begin
				if (int'(p) >= shadow_count)
					r.st = ST_RANGE;
				else
					r.word = shadow_cells[p];
			end
			MODE_DELETE_FIRST, MODE_DELETE_LAST, MODE_DELETE_AT: begin
				if (shadow_count == 0) begin
					r.st = ST_EMPTY;
				end else begin
					if (m == MODE_DELETE_FIRST || (m == MODE_DELETE_AT && p == 0))
						at = 0;
					else if (m == MODE_DELETE_LAST || int'(p) >= shadow_count - 1)
						at = shadow_count - 1;
					else
						at = int'(p);
					r.word = shadow_cells[at];
					for (int k = at; k + 1 < shadow_count; k++)
						shadow_cells[k] = shadow_cells[k+1];
					shadow_count--;
				end
			end
			default: begin
			end
		endcase
		r.cnt = shadow_count[6:0];
		return r;
	endfunction

	always @(posedge clk) begin : watch
		reply_t want;
		reply_t got;
		if (arst_n) begin
			if (done) begin
				if (pending_replies.size() == 0) begin
					$error("result with no item outstanding: word %0d count %0d status %0d",
						word, count, status);
					fail_count++;
				end else begin
					want = pending_replies.pop_front();
					if (word !== want.word) begin
						$error("word: expected %0d, got %0d", want.word, word);
						fail_count++;
					end
					if (count !== want.cnt) begin
						$error("count: expected %0d, got %0d", want.cnt, count);
						fail_count++;
					end
					if (status !== want.st) begin
						$error("status: expected %0d, got %0d", want.st, status);
						fail_count++;
					end
				end
			end
			if (start && !busy) begin
				got = apply_request(mode_r, pos_r, val_r);
				if (cur_typed) begin
					got.word = cur_word;
					got.cnt  = cur_cnt;
					got.st   = cur_st;
				end
				pending_replies.push_back(got);
			end
		end
	end

	// offer one item and hold it until the block takes it
	task automatic offer(request_t r);
		@(negedge clk);
		start     <= 1'b1;
		mode_r    <= r.mode;
		pos_r     <= r.pos;
		val_r     <= r.val;
		cur_typed <= r.typed;
		cur_word  <= r.word;
		cur_cnt   <= r.cnt;
		cur_st    <= r.st;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic pause(int n);
		repeat (n) begin
			@(negedge clk);
			start <= 1'b0;
		end
	endtask

	function automatic request_t random_request(int bias);
		request_t r;
		int       pick;
		int       lim;
		pick = $urandom_range(0, 99);
		// bias 0 grows the store, 1 drains it, 2 is anything goes
		if (bias == 2)
			r.mode = mode_t'($urandom_range(0, 7));
		else if (pick < 72)
			r.mode = mode_t'(bias == 0 ? $urandom_range(0, 2) : $urandom_range(4, 6));
		else if (pick < 86)
			r.mode = MODE_READ_AT;
		else if (pick < 97)
			r.mode = mode_t'(bias == 0 ? $urandom_range(4, 6) : $urandom_range(0, 2));
		else
			r.mode = MODE_NOP;
		lim = (shadow_count > 63) ? 63 : shadow_count;
		if ($urandom_range(0, 3) == 0)
			r.pos = POS_W'($urandom_range(0, 63));
		else
			r.pos = POS_W'($urandom_range(0, lim));
		case ($urandom_range(0, 11))
			0: r.val = 32'sh8000_0000;
			1: r.val = 32'sh7fff_ffff;
			2: r.val = -32'sd1;
			3: r.val = 32'sd0;
			default: r.val = $urandom;
		endcase
		r.typed = 1'b0;
		r.word  = '0;
		r.cnt   = '0;
		r.st    = ST_OK;
		return r;
	endfunction

	initial begin : stimulus
		int left;
		int bias;
		request_t r;
		fail_count = 0;
		shadow_count = 0;
		arst_n    = 1'b0;
		start     = 1'b0;
		mode_r    = MODE_NOP;
		pos_r     = '0;
		val_r     = '0;
		cur_typed = 1'b0;
		cur_word  = '0;
		cur_cnt   = '0;
		cur_st    = ST_OK;

		// every delete and read on an empty store, then inserts of every kind
		directed.push_back('{MODE_DELETE_FIRST, 6'd0, 32'sd0, 1, 32'sd0, 7'd0, ST_EMPTY});
		directed.push_back('{MODE_DELETE_LAST, 6'd0, 32'sd0, 1, 32'sd0, 7'd0, ST_EMPTY});
		directed.push_back('{MODE_DELETE_AT, 6'd63, 32'sd0, 1, 32'sd0, 7'd0, ST_EMPTY});
		directed.push_back('{MODE_READ_AT, 6'd0, 32'sd0, 1, 32'sd0, 7'd0, ST_RANGE});
		directed.push_back('{MODE_NOP, 6'd63, -32'sd1, 1, 32'sd0, 7'd0, ST_OK});
		directed.push_back('{MODE_APPEND, 6'd0, 32'sh7fff_ffff, 1, 32'sd0, 7'd1, ST_OK});
		directed.push_back('{MODE_PREPEND, 6'd63, 32'sh8000_0000, 1, 32'sd0, 7'd2, ST_OK});
		// insert at zero acts as prepend, past the end as append
		directed.push_back('{MODE_INSERT_AT, 6'd0, -32'sd1, 1, 32'sd0, 7'd3, ST_OK});
		directed.push_back('{MODE_INSERT_AT, 6'd63, 32'sh5555_5555, 1, 32'sd0, 7'd4, ST_OK});
		directed.push_back('{MODE_INSERT_AT, 6'd2, 32'shaaaa_aaaa, 0, 32'sd0, 7'd0, ST_OK});
		directed.push_back('{MODE_INSERT_AT, 6'd5, 32'sd0, 0, 32'sd0, 7'd0, ST_OK});
		directed.push_back('{MODE_READ_AT, 6'd63, 32'sd0, 1, 32'sd0, 7'd6, ST_RANGE});
		directed.push_back('{MODE_READ_AT, 6'd6, 32'sd0, 1, 32'sd0, 7'd6, ST_RANGE});
		directed.push_back('{MODE_READ_AT, 6'd0, 32'sd0, 0, 32'sd0, 7'd0, ST_OK});
		directed.push_back('{MODE_READ_AT, 6'd5, 32'sd0, 0, 32'sd0, 7'd0, ST_OK});
		directed.push_back('{MODE_READ_AT, 6'd2, 32'sd0, 0, 32'sd0, 7'd0, ST_OK});
		// delete at zero acts as delete first, near the end as delete last
		directed.push_back('{MODE_DELETE_AT, 6'd0, 32'sd0, 0, 32'sd0, 7'd0, ST_OK});
		directed.push_back('{MODE_DELETE_AT, 6'd4, 32'sd0, 0, 32'sd0, 7'd0, ST_OK});
		directed.push_back('{MODE_DELETE_AT, 6'd63, 32'sd0, 0, 32'sd0, 7'd0, ST_OK});
		directed.push_back('{MODE_DELETE_AT, 6'd1, 32'sd0, 0, 32'sd0, 7'd0, ST_OK});
		directed.push_back('{MODE_DELETE_LAST, 6'd0, 32'sd0, 0, 32'sd0, 7'd0, ST_OK});
		directed.push_back('{MODE_DELETE_FIRST, 6'd0, 32'sd0, 0, 32'sd0, 7'd0, ST_OK});
		directed.push_back('{MODE_DELETE_FIRST, 6'd0, 32'sd0, 1, 32'sd0, 7'd0, ST_EMPTY});

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed[i])
			offer(directed[i]);

		// random part: alternating runs that fill the store past full and drain it past empty
		left = 0;
		bias = 0;
		for (int n = 0; n < N_RANDOM; n++) begin
			if (left == 0) begin
				bias = (bias == 0) ? 1 : (bias == 1 && $urandom_range(0, 2) == 0) ? 2 : 0;
				left = $urandom_range(40, 140);
			end
			left--;
			if (n == N_RANDOM / 2) begin
				pause(1);
				wait (pending_replies.size() == 0);
			end
			if (n < N_RANDOM - CALM_TAIL && $urandom_range(0, 6) == 0)
				pause($urandom_range(1, 19));
			r = random_request(bias);
			offer(r);
		end
		pause(1);

		wait (pending_replies.size() == 0);
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("indexed_sequence_store_unit verification clean");
		else
			$display("indexed_sequence_store_unit verification failed");
		$finish;
	end

	initial begin : watchdog
		#2_000_000;
		$display("indexed_sequence_store_unit verification failed");
		$finish;
	end

endmodule

`default_nettype wire
